/* hw/rtl/rfft_pkg.sv */
// Shared types and helpers for the radix-2 real-input FFT block.
// Holds the channel payload structs, the sequencer states and the saturation helper.
// No dependencies.
package rfft_pkg;

	localparam int DATA_W   = 32;
	localparam int SAMPLE_W = 16;
	localparam int BIN_W    = 12;
	localparam int LOG2_W   = 4;
	// rounded twiddle product width; independent of the twiddle width
	localparam int RND_W    = DATA_W + 3;
	localparam int SUM_W    = RND_W + 1;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                       command;
		logic signed [SAMPLE_W-1:0] sample;
		logic [BIN_W-1:0]           bin_index;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] bin_real;
		logic signed [DATA_W-1:0] bin_imag;
		logic                     result_ok;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_PR_I,
		ST_PR_R,
		ST_PR_WI,
		ST_PR_WR,
		ST_BF_RE,
		ST_BF_RO,
		ST_BF_LD,
		ST_BF_M0,
		ST_BF_M1,
		ST_BF_M2,
		ST_BF_M3,
		ST_BF_WE,
		ST_BF_WO
	} state_t;

	typedef struct packed {
		logic en;
		logic start;
		logic sub;
	} mac_op_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [DATA_W-1:0] r;
		if (v > SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}})))
			r = {1'b0, {(DATA_W-1){1'b1}}};
		else if (v < -SUM_W'(signed'({1'b0, 1'b1, {(DATA_W-1){1'b0}}})))
			r = {1'b1, {(DATA_W-1){1'b0}}};
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

endpackage

/* hw/rtl/rfft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfft_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/rfft_twiddle.sv */
// Twiddle source: quarter-wave sine ROM built at elaboration, registered read.
// Gives the real part (cos) or the imaginary part (-sin) of W^k. Uses rfft_pkg nothing.
module rfft_twiddle #(
	parameter int MAX_LOG2_SIZE = 12,
	parameter int TWIDDLE_BITS  = 18
) (
	input  logic                            clk,
	input  logic [MAX_LOG2_SIZE-2:0]        k,
	input  logic                            sel_sin,
	output logic signed [TWIDDLE_BITS-1:0]  tw
);

	localparam int QUARTER = 1 << (MAX_LOG2_SIZE - 2);
	localparam int FRAC    = TWIDDLE_BITS - 2;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int AW      = MAX_LOG2_SIZE - 1;

	typedef logic [TWIDDLE_BITS-1:0] rom_t [QUARTER+1];

	// Taylor series of sin in Q30, rounded half up to the twiddle fraction
	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		longint      r;
		for (int j = 0; j <= QUARTER; j++) begin
			x    = (HALF_PI_Q30 * 64'(j)) / QUARTER;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 9; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			r = longint'((64'(sum) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
			if (r > (longint'(1) << FRAC))
				r = longint'(1) << FRAC;
			rom[j] = TWIDDLE_BITS'(r);
		end
		return rom;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [AW-1:0]           addr;
	logic                    neg;
	logic [TWIDDLE_BITS-1:0] rom_q;
	logic                    neg_q;

	always_comb begin
		if (!sel_sin) begin
			if (k <= AW'(QUARTER)) begin
				addr = AW'(QUARTER) - k;
				neg  = 1'b0;
			end else begin
				addr = k - AW'(QUARTER);
				neg  = 1'b1;
			end
		end else begin
			addr = (k <= AW'(QUARTER)) ? k : AW'(2 * QUARTER) - k;
			neg  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= ROM[addr];
		neg_q <= neg;
	end

	assign tw = neg_q ? -signed'(rom_q) : signed'(rom_q);

endmodule

/* hw/rtl/rfft_mac.sv */
// Shared multiply-accumulate unit for the butterflies, with round-to-nearest output.
// Depends on rfft_pkg (mac_op_t, widths).
module rfft_mac #(
	parameter int TWIDDLE_BITS = 18
) (
	input  logic                                 clk,
	input  rfft_pkg::mac_op_t                    op,
	input  logic signed [rfft_pkg::DATA_W-1:0]   a,
	input  logic signed [TWIDDLE_BITS-1:0]       b,
	output logic signed [rfft_pkg::RND_W-1:0]    rnd
);

	localparam int FRAC = TWIDDLE_BITS - 2;
	localparam int PW   = rfft_pkg::DATA_W + TWIDDLE_BITS;
	localparam int ACW  = PW + 1;

	logic signed [PW-1:0]  prod;
	logic signed [ACW-1:0] term;
	logic signed [ACW-1:0] acc_q;
	logic signed [ACW-1:0] biased;

	assign prod = a * b;
	assign term = op.sub ? -ACW'(prod) : ACW'(prod);

	always_ff @(posedge clk) begin
		if (op.en)
			acc_q <= (op.start ? '0 : acc_q) + term;
	end

	// ties go toward plus infinity
	assign biased = acc_q + signed'({{(ACW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}});
	assign rnd    = rfft_pkg::RND_W'(biased >>> FRAC);

endmodule

/* hw/rtl/radix2_fft_real_input.sv */
// Radix-2 decimation-in-time FFT over 2^log2_size real samples, unscaled.
// Block usage:
//  - req channel (req_valid/req_stall): command 0 loads the next sample, command 1
//    reads bin bin_index. A transfer happens when req_valid is high and req_stall low.
//  - rsp channel (rsp_valid/rsp_stall): one result per read command, none per load.
//  - cfg channel (cfg_valid/cfg_ready): writes log2_size (clamped to the supported
//    range) and discards any partial frame. Write only while idle.
//  - The load that completes a frame starts the transform: a bit-reverse pass,
//    then N/2*log2(N) butterflies, each reading its even and odd points, doing
//    four multiply-accumulate steps and writing both results, on one shared
//    multiply-accumulate unit and one point RAM.
//    req_stall stays high during the transform.
//  - A read goes through the point RAM's registered port; its result sits in an
//    output register until taken, so loads continue while a result waits. A read
//    also waits while the output register is full and stalled.
//  - Reset clears the frame count and the done flag; log2_size returns to its
//    maximum. The point RAM is not cleared.
// Depends on rfft_pkg, rfft_ram, rfft_twiddle, rfft_mac.
module radix2_fft_real_input #(
	parameter int MAX_LOG2_SIZE = 12,
	parameter int MIN_LOG2_SIZE = 5,
	parameter int TWIDDLE_BITS  = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  rfft_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output rfft_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rfft_pkg::LOG2_W-1:0]   cfg_data
);

	localparam int AW = MAX_LOG2_SIZE;
	localparam int SW = $clog2(MAX_LOG2_SIZE + 1);
	localparam int DW = rfft_pkg::DATA_W;

	rfft_pkg::state_t state_q, state_d;

	logic [SW-1:0]   lg_q;
	logic [AW:0]     count_q;
	logic            done_q;
	logic [AW-1:0]   idx_q;
	logic [AW-2:0]   j_q;
	logic [SW-1:0]   stage_q;
	logic [2*DW-1:0] a_q;
	logic [2*DW-1:0] e_q;
	logic [2*DW-1:0] x_q;
	logic signed [TWIDDLE_BITS-1:0] wr_q, wi_q;
	logic signed [rfft_pkg::RND_W-1:0] pr_q, pi_q;
	logic            ok_q;
	logic            rsp_valid_q;
	rfft_pkg::rsp_t  rsp_q;

	logic [AW:0]     n_full;
	logic [AW-1:0]   mask;
	logic [AW-1:0]   rev;
	logic [AW-1:0]   ridx;
	logic [AW-1:0]   hbit;
	logic [AW-1:0]   jw;
	logic [AW-1:0]   lowp;
	logic [AW-1:0]   e_addr;
	logic [AW-1:0]   o_addr;
	logic [AW-2:0]   tw_k;
	logic            last_j;
	logic            req_xfer;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [2*DW-1:0] wdata;
	logic [AW-1:0]   raddr;
	logic [2*DW-1:0] rdata;

	logic            tw_sin;
	logic signed [TWIDDLE_BITS-1:0] tw;
	rfft_pkg::mac_op_t mac_op;
	logic signed [DW-1:0] mac_a;
	logic signed [TWIDDLE_BITS-1:0] mac_b;
	logic signed [rfft_pkg::RND_W-1:0] rnd;

	logic [DW-1:0] sum_re, sum_im;

	rfft_ram #(.WIDTH(2 * DW), .DEPTH(1 << AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	rfft_twiddle #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE), .TWIDDLE_BITS(TWIDDLE_BITS)) u_tw (
		.clk     (clk),
		.k       (tw_k),
		.sel_sin (tw_sin),
		.tw      (tw)
	);

	rfft_mac #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_mac (
		.clk (clk),
		.op  (mac_op),
		.a   (mac_a),
		.b   (mac_b),
		.rnd (rnd)
	);

	assign n_full = (AW + 1)'(1) << lg_q;
	assign mask   = AW'(n_full - (AW + 1)'(1));

	always_comb begin
		for (int b = 0; b < AW; b++)
			rev[b] = idx_q[AW-1-b];
	end
	assign ridx = rev >> (SW'(AW) - lg_q);

	// butterfly j of the stage: insert a zero at bit stage-1 for the even index
	assign hbit   = AW'(1) << (stage_q - SW'(1));
	assign jw     = AW'(j_q);
	assign lowp   = jw & (hbit - AW'(1));
	assign e_addr = ((jw & ~(hbit - AW'(1))) << 1) | lowp;
	assign o_addr = e_addr | hbit;
	assign tw_k   = (AW - 1)'(lowp << (SW'(AW) - stage_q));
	assign last_j = j_q == (AW - 1)'(mask >> 1);

	assign req_stall = (state_q != rfft_pkg::ST_IDLE)
		| (req.command & rsp_valid_q & rsp_stall);
	assign req_xfer  = req_valid & ~req_stall;
	assign cfg_ready = state_q == rfft_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rfft_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = rdata;
		raddr   = idx_q;
		tw_sin  = 1'b0;
		mac_op  = '0;
		mac_a   = signed'(x_q[2*DW-1:DW]);
		mac_b   = wr_q;
		sum_re  = rfft_pkg::sat32(rfft_pkg::SUM_W'(signed'(e_q[2*DW-1:DW]))
			+ rfft_pkg::SUM_W'(pr_q));
		sum_im  = rfft_pkg::sat32(rfft_pkg::SUM_W'(signed'(e_q[DW-1:0]))
			+ rfft_pkg::SUM_W'(rnd));
		case (state_q)
			rfft_pkg::ST_IDLE: begin
				raddr = AW'(req.bin_index);
				if (req_xfer) begin
					if (req.command == rfft_pkg::CMD_LOAD) begin
						we      = 1'b1;
						waddr   = count_q[AW-1:0];
						wdata   = {DW'(req.sample), {DW{1'b0}}};
						if (count_q + (AW + 1)'(1) == n_full)
							state_d = rfft_pkg::ST_PR_I;
					end else begin
						state_d = rfft_pkg::ST_READ;
					end
				end
			end
			rfft_pkg::ST_READ: state_d = rfft_pkg::ST_IDLE;
			rfft_pkg::ST_PR_I: begin
				if (idx_q < ridx)
					state_d = rfft_pkg::ST_PR_R;
				else if (idx_q == mask)
					state_d = rfft_pkg::ST_BF_RE;
			end
			rfft_pkg::ST_PR_R: begin
				raddr   = ridx;
				state_d = rfft_pkg::ST_PR_WI;
			end
			rfft_pkg::ST_PR_WI: begin
				we      = 1'b1;
				state_d = rfft_pkg::ST_PR_WR;
			end
			rfft_pkg::ST_PR_WR: begin
				we      = 1'b1;
				waddr   = ridx;
				wdata   = a_q;
				state_d = (idx_q == mask) ? rfft_pkg::ST_BF_RE : rfft_pkg::ST_PR_I;
			end
			rfft_pkg::ST_BF_RE: begin
				raddr   = e_addr;
				state_d = rfft_pkg::ST_BF_RO;
			end
			rfft_pkg::ST_BF_RO: begin
				raddr   = o_addr;
				tw_sin  = 1'b1;
				state_d = rfft_pkg::ST_BF_LD;
			end
			rfft_pkg::ST_BF_LD: state_d = rfft_pkg::ST_BF_M0;
			rfft_pkg::ST_BF_M0: begin
				mac_op  = '{en: 1'b1, start: 1'b1, sub: 1'b0};
				state_d = rfft_pkg::ST_BF_M1;
			end
			rfft_pkg::ST_BF_M1: begin
				mac_op  = '{en: 1'b1, start: 1'b0, sub: 1'b1};
				mac_a   = signed'(x_q[DW-1:0]);
				mac_b   = wi_q;
				state_d = rfft_pkg::ST_BF_M2;
			end
			rfft_pkg::ST_BF_M2: begin
				mac_op  = '{en: 1'b1, start: 1'b1, sub: 1'b0};
				mac_a   = signed'(x_q[DW-1:0]);
				state_d = rfft_pkg::ST_BF_M3;
			end
			rfft_pkg::ST_BF_M3: begin
				mac_op  = '{en: 1'b1, start: 1'b0, sub: 1'b0};
				mac_b   = wi_q;
				state_d = rfft_pkg::ST_BF_WE;
			end
			rfft_pkg::ST_BF_WE: begin
				we      = 1'b1;
				waddr   = e_addr;
				wdata   = {sum_re, sum_im};
				state_d = rfft_pkg::ST_BF_WO;
			end
			rfft_pkg::ST_BF_WO: begin
				we      = 1'b1;
				waddr   = o_addr;
				sum_re  = rfft_pkg::sat32(rfft_pkg::SUM_W'(signed'(e_q[2*DW-1:DW]))
					- rfft_pkg::SUM_W'(pr_q));
				sum_im  = rfft_pkg::sat32(rfft_pkg::SUM_W'(signed'(e_q[DW-1:0]))
					- rfft_pkg::SUM_W'(pi_q));
				wdata   = {sum_re, sum_im};
				if (last_j && stage_q == lg_q)
					state_d = rfft_pkg::ST_IDLE;
				else
					state_d = rfft_pkg::ST_BF_RE;
			end
			default: state_d = rfft_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q        <= SW'(MAX_LOG2_SIZE);
			count_q     <= '0;
			done_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			j_q         <= '0;
			stage_q     <= SW'(1);
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (32'(cfg_data) < MIN_LOG2_SIZE)
					lg_q <= SW'(MIN_LOG2_SIZE);
				else if (32'(cfg_data) > MAX_LOG2_SIZE)
					lg_q <= SW'(MAX_LOG2_SIZE);
				else
					lg_q <= SW'(cfg_data);
				count_q <= '0;
				done_q  <= 1'b0;
			end
			case (state_q)
				rfft_pkg::ST_IDLE: begin
					if (req_xfer && req.command == rfft_pkg::CMD_LOAD) begin
						done_q <= 1'b0;
						idx_q  <= '0;
						if (count_q + (AW + 1)'(1) == n_full)
							count_q <= '0;
						else
							count_q <= count_q + (AW + 1)'(1);
					end
				end
				rfft_pkg::ST_READ: rsp_valid_q <= 1'b1;
				rfft_pkg::ST_PR_I: begin
					if (!(idx_q < ridx)) begin
						if (idx_q == mask) begin
							j_q     <= '0;
							stage_q <= SW'(1);
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				rfft_pkg::ST_PR_WR: begin
					if (idx_q == mask) begin
						j_q     <= '0;
						stage_q <= SW'(1);
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				rfft_pkg::ST_BF_WO: begin
					if (last_j) begin
						j_q <= '0;
						if (stage_q == lg_q)
							done_q <= 1'b1;
						else
							stage_q <= stage_q + SW'(1);
					end else begin
						j_q <= j_q + (AW - 1)'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == rfft_pkg::ST_IDLE && req_xfer)
			ok_q <= done_q && 32'(req.bin_index) < 32'(n_full);
		if (state_q == rfft_pkg::ST_READ) begin
			rsp_q.bin_real  <= ok_q ? rdata[2*DW-1:DW] : '0;
			rsp_q.bin_imag  <= ok_q ? rdata[DW-1:0] : '0;
			rsp_q.result_ok <= done_q;
		end
		if (state_q == rfft_pkg::ST_PR_R)
			a_q <= rdata;
		if (state_q == rfft_pkg::ST_BF_RO) begin
			e_q  <= rdata;
			wr_q <= tw;
		end
		if (state_q == rfft_pkg::ST_BF_LD) begin
			x_q  <= rdata;
			wi_q <= tw;
		end
		if (state_q == rfft_pkg::ST_BF_M2)
			pr_q <= rnd;
		if (state_q == rfft_pkg::ST_BF_WE)
			pi_q <= rnd;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_read_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req.command == rfft_pkg::CMD_READ) |=> ##1 rsp_valid)
		else $error("read transfer did not produce a result");

	a_rsp_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == rfft_pkg::ST_READ)
		else $error("result appeared without a read");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < n_full)
		else $error("frame count beyond transform length");

	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req.command == rfft_pkg::CMD_LOAD
			&& count_q + (AW + 1)'(1) == n_full)
		|=> state_q == rfft_pkg::ST_PR_I && count_q == '0 && !done_q)
		else $error("completed frame did not start the transform");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> state_q == rfft_pkg::ST_IDLE)
		else $error("transform flagged done while still busy");
`endif

endmodule
